// ===== rtl/kvlt_pkg.sv =====
// Shared types and constants for the key/value line tokenizer.
// Depends on nothing; every other file of the block refers to it by scoped names.
package kvlt_pkg;

    // Default sizes handed down from the top level.
    localparam int SPACE_DEPTH = 16;
    localparam int QUEUE_DEPTH = 4;

    // Result kinds as they appear on the kind port.
    localparam logic [2:0] KIND_KEY    = 3'd0;
    localparam logic [2:0] KIND_VALUE  = 3'd1;
    localparam logic [2:0] KIND_PAIR   = 3'd2;
    localparam logic [2:0] KIND_ERROR  = 3'd3;
    localparam logic [2:0] KIND_ACCEPT = 3'd4;

    // Operations passed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_PUSH        = 2'd0,  // store one whitespace byte, no result
        OP_EMIT        = 2'd1,  // one result, marked last
        OP_PAIR_ACCEPT = 2'd2,  // pair end followed by accept
        OP_FLUSH       = 2'd3   // held whitespace, then the value byte
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] kind;   // kind for OP_EMIT
        logic [7:0] ch;     // byte for OP_EMIT, OP_PUSH and OP_FLUSH
        logic       first;  // OP_PUSH: this byte starts a new whitespace run
    } cmd_t;

endpackage

// ===== rtl/kvlt_front.sv =====
// Front end of the tokenizer: accepts bytes, tracks the line grammar and
// issues commands. Depends on kvlt_pkg for the command type and result kinds.
module kvlt_front #(
    parameter int SPACE_DEPTH = kvlt_pkg::SPACE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      char_in,
    input  logic            end_marker,
    output logic            cmd_valid,
    output kvlt_pkg::cmd_t  cmd,
    input  logic            queue_full
);

    localparam int CNT_W = $clog2(SPACE_DEPTH + 1);

    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [7:0] {
        PH_KEY_START   = 8'b0000_0001,
        PH_KEY         = 8'b0000_0010,
        PH_KEY_END     = 8'b0000_0100,
        PH_VALUE_START = 8'b0000_1000,
        PH_VALUE       = 8'b0001_0000,
        PH_VALUE_WS    = 8'b0010_0000,
        PH_VALUE_END   = 8'b0100_0000,
        PH_ERROR       = 8'b1000_0000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               has_cmd;
    logic               accept;
    logic               ws;
    logic               letter;

    // Whitespace is space plus the control bytes TAB through CR.
    assign ws     = (char_in == 8'h20) || (char_in >= 8'h09 && char_in <= 8'h0D);
    assign letter = (char_in >= 8'h41 && char_in <= 8'h5A) ||
                    (char_in >= 8'h61 && char_in <= 8'h7A);

    assign in_stall  = queue_full;
    assign accept    = in_valid && !queue_full;
    assign cmd_valid = in_valid && has_cmd;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        has_cmd    = 1'b0;
        cmd.op     = kvlt_pkg::OP_EMIT;
        cmd.kind   = kvlt_pkg::KIND_ERROR;
        cmd.ch     = 8'h00;
        cmd.first  = 1'b0;
        if (end_marker)
        begin
            has_cmd    = 1'b1;
            phase_next = PH_KEY_START;
            count_next = '0;
            case (phase_reg)
                PH_VALUE_START, PH_VALUE, PH_VALUE_WS:
                begin
                    cmd.op = kvlt_pkg::OP_PAIR_ACCEPT;
                end
                PH_KEY_START:
                begin
                    cmd.kind = kvlt_pkg::KIND_ACCEPT;
                end
                default:
                begin
                    cmd.kind = kvlt_pkg::KIND_ERROR;
                end
            endcase
        end
        else
        begin
            case (phase_reg)
                PH_KEY_START:
                begin
                    if (ws)
                    begin
                        has_cmd = 1'b0;
                    end
                    else if (letter)
                    begin
                        has_cmd    = 1'b1;
                        cmd.kind   = kvlt_pkg::KIND_KEY;
                        cmd.ch     = char_in;
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        has_cmd    = 1'b1;
                        phase_next = PH_ERROR;
                        count_next = '0;
                    end
                end
                PH_KEY:
                begin
                    if (char_in == CH_EQUAL)
                    begin
                        phase_next = PH_VALUE_START;
                    end
                    else if (ws)
                    begin
                        phase_next = PH_KEY_END;
                    end
                    else if (letter)
                    begin
                        has_cmd  = 1'b1;
                        cmd.kind = kvlt_pkg::KIND_KEY;
                        cmd.ch   = char_in;
                    end
                    else
                    begin
                        has_cmd    = 1'b1;
                        phase_next = PH_ERROR;
                        count_next = '0;
                    end
                end
                PH_KEY_END:
                begin
                    if (char_in == CH_EQUAL)
                    begin
                        phase_next = PH_VALUE_START;
                    end
                    else if (!ws)
                    begin
                        has_cmd    = 1'b1;
                        phase_next = PH_ERROR;
                        count_next = '0;
                    end
                end
                PH_VALUE_START:
                begin
                    if (!ws)
                    begin
                        has_cmd    = 1'b1;
                        cmd.kind   = kvlt_pkg::KIND_VALUE;
                        cmd.ch     = char_in;
                        phase_next = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    if (char_in == CH_CR)
                    begin
                        phase_next = PH_VALUE_END;
                    end
                    else if (char_in == CH_LF)
                    begin
                        has_cmd    = 1'b1;
                        cmd.kind   = kvlt_pkg::KIND_PAIR;
                        phase_next = PH_KEY_START;
                        count_next = '0;
                    end
                    else if (ws)
                    begin
                        // A new run always fits, since the buffer holds at least one byte.
                        has_cmd    = 1'b1;
                        cmd.op     = kvlt_pkg::OP_PUSH;
                        cmd.ch     = char_in;
                        cmd.first  = 1'b1;
                        count_next = CNT_W'(1);
                        phase_next = PH_VALUE_WS;
                    end
                    else
                    begin
                        has_cmd  = 1'b1;
                        cmd.kind = kvlt_pkg::KIND_VALUE;
                        cmd.ch   = char_in;
                    end
                end
                PH_VALUE_WS:
                begin
                    if (char_in == CH_CR)
                    begin
                        count_next = '0;
                        phase_next = PH_VALUE_END;
                    end
                    else if (char_in == CH_LF)
                    begin
                        has_cmd    = 1'b1;
                        cmd.kind   = kvlt_pkg::KIND_PAIR;
                        phase_next = PH_KEY_START;
                        count_next = '0;
                    end
                    else if (ws)
                    begin
                        has_cmd = 1'b1;
                        if (count_reg >= CNT_W'(SPACE_DEPTH))
                        begin
                            phase_next = PH_ERROR;
                            count_next = '0;
                        end
                        else
                        begin
                            cmd.op     = kvlt_pkg::OP_PUSH;
                            cmd.ch     = char_in;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        has_cmd    = 1'b1;
                        cmd.op     = kvlt_pkg::OP_FLUSH;
                        cmd.ch     = char_in;
                        count_next = '0;
                        phase_next = PH_VALUE;
                    end
                end
                PH_VALUE_END:
                begin
                    has_cmd    = 1'b1;
                    count_next = '0;
                    if (char_in == CH_LF)
                    begin
                        cmd.kind   = kvlt_pkg::KIND_PAIR;
                        phase_next = PH_KEY_START;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                default:
                begin
                    has_cmd = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KEY_START;
            count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/kvlt_queue.sv =====
// Short command queue between the tokenizer front end and back end.
// Depends on kvlt_pkg for the command type.
module kvlt_queue #(
    parameter int DEPTH = kvlt_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  kvlt_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output kvlt_pkg::cmd_t  head_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    kvlt_pkg::cmd_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/kvlt_back.sv =====
// Back end of the tokenizer: executes queued commands, holds the whitespace
// buffer and drives the registered result stage. Depends on kvlt_pkg.
module kvlt_back #(
    parameter int SPACE_DEPTH = kvlt_pkg::SPACE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  kvlt_pkg::cmd_t  head_cmd,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [2:0]      kind,
    output logic [7:0]      char_out,
    output logic            last
);

    localparam int CNT_W = $clog2(SPACE_DEPTH + 1);
    localparam int IDX_W = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SECOND = 5'b00010,
        S_PRIME  = 5'b00100,
        S_FLUSH  = 5'b01000,
        S_TAIL   = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [7:0]         space_mem [SPACE_DEPTH];
    logic [7:0]         rd_data_reg;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   wr_cnt_reg, wr_cnt_next;
    logic [7:0]         tail_reg, tail_next;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;

    logic               out_valid_reg, out_valid_next;
    logic [2:0]         kind_reg, kind_next;
    logic [7:0]         char_reg, char_next;
    logic               last_reg, last_next;
    logic               load_ok;
    logic               load;

    assign load_ok   = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        wr_cnt_next = wr_cnt_reg;
        tail_next   = tail_reg;
        pop         = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = wr_cnt_reg[IDX_W-1:0];
        load        = 1'b0;
        kind_next   = kvlt_pkg::KIND_ERROR;
        char_next   = 8'h00;
        last_next   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    case (head_cmd.op)
                        kvlt_pkg::OP_PUSH:
                        begin
                            pop    = 1'b1;
                            mem_we = 1'b1;
                            if (head_cmd.first)
                            begin
                                mem_waddr   = '0;
                                wr_cnt_next = CNT_W'(1);
                            end
                            else
                            begin
                                wr_cnt_next = wr_cnt_reg + CNT_W'(1);
                            end
                        end
                        kvlt_pkg::OP_EMIT:
                        begin
                            if (load_ok)
                            begin
                                pop       = 1'b1;
                                load      = 1'b1;
                                kind_next = head_cmd.kind;
                                char_next = head_cmd.ch;
                            end
                        end
                        kvlt_pkg::OP_PAIR_ACCEPT:
                        begin
                            if (load_ok)
                            begin
                                pop        = 1'b1;
                                load       = 1'b1;
                                kind_next  = kvlt_pkg::KIND_PAIR;
                                last_next  = 1'b0;
                                state_next = S_SECOND;
                            end
                        end
                        default:
                        begin
                            pop         = 1'b1;
                            tail_next   = head_cmd.ch;
                            rd_idx_next = '0;
                            state_next  = S_PRIME;
                        end
                    endcase
                end
            end
            S_SECOND:
            begin
                if (load_ok)
                begin
                    load       = 1'b1;
                    kind_next  = kvlt_pkg::KIND_ACCEPT;
                    state_next = S_IDLE;
                end
            end
            S_PRIME:
            begin
                // The buffer read address settles here; data is valid next cycle.
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (load_ok)
                begin
                    load      = 1'b1;
                    kind_next = kvlt_pkg::KIND_VALUE;
                    char_next = rd_data_reg;
                    last_next = 1'b0;
                    if ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == wr_cnt_reg)
                    begin
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                        state_next  = S_PRIME;
                    end
                end
            end
            S_TAIL:
            begin
                if (load_ok)
                begin
                    load       = 1'b1;
                    kind_next  = kvlt_pkg::KIND_VALUE;
                    char_next  = tail_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            space_mem[mem_waddr] <= head_cmd.ch;
        end
        rd_data_reg <= space_mem[rd_idx_reg];
        tail_reg    <= tail_next;
        if (load)
        begin
            kind_reg <= kind_next;
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_idx_reg    <= '0;
            wr_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            wr_cnt_reg    <= wr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/key_value_line_tokenizer_unit.sv =====
// Top level of the key/value line tokenizer: front end, command queue, back end.
// Depends on kvlt_pkg, kvlt_front, kvlt_queue and kvlt_back.
//
// The unit reads text one byte per input transaction and streams out the
// key characters, value characters and pair-end marks of lines of the form
// "key = value", finishing with an accept or an error transaction when a
// transaction with end_marker set arrives. A byte that produces at most one
// result, or none, issues at most one command, so ordinary text flows at one
// byte per clock while the queue has room. The front end decides each byte in
// the cycle it is accepted and hands a command to a four-entry queue; the input
// stalls only while that queue is full. The back end drains the queue: a stored
// whitespace byte is written to the buffer, a single result is loaded into the
// output register, and the end of text after a value loads the pair end and
// then the accept. When a non-space byte follows a run of held whitespace
// bytes, the back end takes the command, replays the run from its buffer with
// one buffer read and one output load per byte and then loads the new byte;
// that burst is what pushes back on the input. Results leave through an output
// register, so the front end keeps accepting bytes while a result waits on
// out_stall. The whitespace buffer holds SPACE_DEPTH bytes; a longer run inside
// a value is an error. After an error, bytes are consumed without results until
// the end marker, after which the unit is back in its reset state.
module key_value_line_tokenizer_unit #(
    parameter int SPACE_DEPTH = kvlt_pkg::SPACE_DEPTH,
    parameter int QUEUE_DEPTH = kvlt_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_in,
    input  logic        end_marker,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  char_out,
    output logic        last
);

    logic               cmd_valid;
    kvlt_pkg::cmd_t     cmd;
    logic               queue_full;
    logic               head_valid;
    kvlt_pkg::cmd_t     head_cmd;
    logic               pop;

    // Front end: grammar tracking and whitespace run accounting.
    kvlt_front #(
        .SPACE_DEPTH (SPACE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_in    (char_in),
        .end_marker (end_marker),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .queue_full (queue_full)
    );

    // Decoupling queue; commands keep byte order.
    kvlt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_valid),
        .push_cmd   (cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back end: whitespace buffer, replay sequencer and output register.
    kvlt_back #(
        .SPACE_DEPTH (SPACE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .char_out   (char_out),
        .last       (last)
    );

    // Accept and error results always close the results of their byte.
    a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == kvlt_pkg::KIND_ERROR || kind == kvlt_pkg::KIND_ACCEPT))
        |-> last)
        else $error("accept or error result not marked last");

    // Only key and value results carry a character.
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != kvlt_pkg::KIND_KEY && kind != kvlt_pkg::KIND_VALUE)
        |-> (char_out == 8'h00))
        else $error("non-character result carries a character");

    // A pair end that is not last must be followed by the accept of the end marker.
    a_pair_then_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && kind == kvlt_pkg::KIND_PAIR && !last)
        |=> (out_valid && kind == kvlt_pkg::KIND_ACCEPT))
        else $error("pair end at end of text not followed by accept");

endmodule

// ===== dv/kvlt_tb_pkg.sv =====
// Checking support for the key/value line tokenizer testbench: the token type,
// character helpers and the scoreboard that predicts and matches results.
// Depends on kvlt_pkg for the result kinds and the whitespace buffer depth.
`timescale 1ns / 1ps

package kvlt_tb_pkg;

    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_VT  = 8'h0B;
    localparam logic [7:0] CHAR_FF  = 8'h0C;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_EQ  = 8'h3D;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        logic       last;
    } token_t;

    typedef enum int {
        AT_KEY_START,
        IN_KEY,
        AFTER_KEY,
        AT_VALUE_START,
        IN_VALUE,
        IN_VALUE_SPACE,
        AFTER_CR,
        IN_ERROR
    } line_phase_t;

    function automatic bit is_space(logic [7:0] c);
        return c == CHAR_SP || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    class token_scoreboard;

        line_phase_t phase;
        logic [7:0]  held [kvlt_pkg::SPACE_DEPTH];
        int          held_count;
        token_t      burst [$];
        token_t      tokens_due [$];
        int          mismatches;

        function new();
            phase      = AT_KEY_START;
            held_count = 0;
            mismatches = 0;
        endfunction

        function void emit(logic [2:0] k, logic [7:0] c);
            token_t t;
            t.kind = k;
            t.ch   = c;
            t.last = 1'b0;
            burst.insert(burst.size(), t);
        endfunction

        function void fail_line();
            emit(kvlt_pkg::KIND_ERROR, 8'h00);
            phase      = IN_ERROR;
            held_count = 0;
        endfunction

        function void close_pair();
            emit(kvlt_pkg::KIND_PAIR, 8'h00);
            phase      = AT_KEY_START;
            held_count = 0;
        endfunction

        // A full buffer turns one more whitespace byte into an error.
        function void hold_space(logic [7:0] c);
            if (held_count >= kvlt_pkg::SPACE_DEPTH) begin
                fail_line();
            end
            else begin
                held[held_count] = c;
                held_count++;
                phase = IN_VALUE_SPACE;
            end
        endfunction

        function void flag(string what);
            mismatches++;
            $display("%0t: %s", $time, what);
        endfunction

        // Works out the results of one accepted byte and queues them in order.
        function void note_byte(logic [7:0] c, logic at_end);
            if (at_end) begin
                case (phase)
                    AT_VALUE_START, IN_VALUE, IN_VALUE_SPACE:
                    begin
                        emit(kvlt_pkg::KIND_PAIR, 8'h00);
                        emit(kvlt_pkg::KIND_ACCEPT, 8'h00);
                    end
                    AT_KEY_START: emit(kvlt_pkg::KIND_ACCEPT, 8'h00);
                    default:      emit(kvlt_pkg::KIND_ERROR, 8'h00);
                endcase
                phase      = AT_KEY_START;
                held_count = 0;
            end
            else begin
                case (phase)
                    AT_KEY_START:
                    begin
                        if (is_letter(c)) begin
                            emit(kvlt_pkg::KIND_KEY, c);
                            phase = IN_KEY;
                        end
                        else if (!is_space(c)) begin
                            fail_line();
                        end
                    end
                    IN_KEY:
                    begin
                        if (c == CHAR_EQ)       phase = AT_VALUE_START;
                        else if (is_space(c))   phase = AFTER_KEY;
                        else if (is_letter(c))  emit(kvlt_pkg::KIND_KEY, c);
                        else                    fail_line();
                    end
                    AFTER_KEY:
                    begin
                        if (c == CHAR_EQ)       phase = AT_VALUE_START;
                        else if (!is_space(c))  fail_line();
                    end
                    AT_VALUE_START:
                    begin
                        if (!is_space(c)) begin
                            emit(kvlt_pkg::KIND_VALUE, c);
                            phase = IN_VALUE;
                        end
                    end
                    IN_VALUE:
                    begin
                        if (c == CHAR_CR) begin
                            phase = AFTER_CR;
                        end
                        else if (c == CHAR_LF) begin
                            close_pair();
                        end
                        else if (is_space(c)) begin
                            held_count = 0;
                            hold_space(c);
                        end
                        else begin
                            emit(kvlt_pkg::KIND_VALUE, c);
                        end
                    end
                    IN_VALUE_SPACE:
                    begin
                        if (c == CHAR_CR) begin
                            held_count = 0;
                            phase      = AFTER_CR;
                        end
                        else if (c == CHAR_LF) begin
                            close_pair();
                        end
                        else if (is_space(c)) begin
                            hold_space(c);
                        end
                        else begin
                            for (int i = 0; i < held_count; i++) begin
                                emit(kvlt_pkg::KIND_VALUE, held[i]);
                            end
                            emit(kvlt_pkg::KIND_VALUE, c);
                            held_count = 0;
                            phase      = IN_VALUE;
                        end
                    end
                    AFTER_CR:
                    begin
                        if (c == CHAR_LF) close_pair();
                        else              fail_line();
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (burst.size() > 0) begin
                burst[burst.size() - 1].last = 1'b1;
                foreach (burst[i]) begin
                    tokens_due.insert(tokens_due.size(), burst[i]);
                end
                burst.delete();
            end
        endfunction

        // Compares one accepted result with the oldest expected token.
        function void check_token(logic [2:0] k, logic [7:0] c, logic lst);
            token_t want;
            if (tokens_due.size() == 0) begin
                flag($sformatf("result kind %0d char %02h last %0b arrived with none expected",
                               k, c, lst));
                return;
            end
            want = tokens_due.pop_front();
            if (want.kind !== k) begin
                flag($sformatf("kind expected %0d, actual %0d", want.kind, k));
            end
            if (want.ch !== c) begin
                flag($sformatf("char_out expected %02h, actual %02h", want.ch, c));
            end
            if (want.last !== lst) begin
                flag($sformatf("last expected %0b, actual %0b", want.last, lst));
            end
        endfunction

    endclass

endpackage

// ===== dv/tb_top.sv =====
// Top of the key/value line tokenizer testbench: clock, reset, byte driver,
// result receiver, watchdog and the test sequence.
// Depends on kvlt_pkg, kvlt_tb_pkg and key_value_line_tokenizer_unit.
`timescale 1ns / 1ps

module tb_top;

    // Cycles without any transaction on either side before the run is
    // declared hung. The longest legal quiet stretch is the deliberate
    // receiver hold-off plus a sender gap, far below this.
    localparam int QUIET_LIMIT     = 3000;
    localparam int LONG_HOLD       = 250;
    localparam int MAX_GAP         = 40;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int TAIL_CYCLES     = 20;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] char_in;
    logic       end_marker;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] kind;
    logic [7:0] char_out;
    logic       last;

    int  send_idle_pct = 0;
    int  stall_pct     = 0;
    bit  hold_request  = 1'b0;
    bit  hold_served   = 1'b0;
    int  quiet_cycles  = 0;
    int  bytes_sent    = 0;
    bit  moved;

    kvlt_tb_pkg::token_scoreboard token_board;

    key_value_line_tokenizer_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_in    (char_in),
        .end_marker (end_marker),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .char_out   (char_out),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver. Each cycle it stalls at the current random rate. When the
    // sequence asks for a hold-off it keeps out_stall high for the LONG_HOLD
    // hold-off, counted here, so the output register and the command queue
    // fill up and the block has to push back on its input.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                out_stall  <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor and watchdog. Both sides are sampled at the rising edge, so the
    // values seen are the ones that stood before the edge. An accepted input
    // transaction feeds the predictor; an accepted output transaction is
    // checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n) begin
            moved = 1'b0;
            if (in_valid && !in_stall) begin
                token_board.note_byte(char_in, end_marker);
                moved = 1'b1;
            end
            if (out_valid && !out_stall) begin
                token_board.check_token(kind, char_out, last);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offers one byte. The idle gap is drawn before the byte is offered and
    // never looks at in_stall. Once valid is up, the payload is held until
    // the transaction is accepted. Entered and left at a rising edge.
    task automatic push_byte(input logic [7:0] c, input logic at_end);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        char_in    <= c;
        end_marker <= at_end;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    // The end marker carries a random byte, which the block has to ignore.
    task automatic send_end();
        push_byte(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i], 1'b0);
        end
    endtask

    // Drops valid and waits until every predicted result has come out. The
    // first edge lets the monitor record the byte accepted at this edge.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (token_board.tokens_due.size() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] random_space();
        case ($urandom_range(3))
            0:       return kvlt_tb_pkg::CHAR_SP;
            1:       return kvlt_tb_pkg::CHAR_TAB;
            2:       return kvlt_tb_pkg::CHAR_VT;
            default: return kvlt_tb_pkg::CHAR_FF;
        endcase
    endfunction

    function automatic logic [7:0] random_letter();
        if ($urandom_range(1) == 0) return 8'(8'h41 + $urandom_range(25));
        return 8'(8'h61 + $urandom_range(25));
    endfunction

    // Any byte that is not whitespace, high bytes and '=' included.
    function automatic logic [7:0] random_solid();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (kvlt_tb_pkg::is_space(c));
        return c;
    endfunction

    // One line of text. Most lines are well formed with random content, so
    // the value phases and the whitespace replay get real exercise; the rest
    // is raw noise, keys with a stray byte, a lone CR, or a missing newline.
    // Interior whitespace runs sometimes sit right at the buffer depth, one
    // short of it, or one past it, which is the overflow error.
    task automatic send_random_line();
        int roll;
        int n;
        int runs;
        roll = $urandom_range(99);
        if (roll < 8) begin
            n = $urandom_range(1, 6);
            repeat (n) push_byte(8'($urandom_range(255)), 1'b0);
        end
        else begin
            repeat ($urandom_range(0, 2)) push_byte(random_space(), 1'b0);
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                if ($urandom_range(99) < 4) push_byte(8'($urandom_range(255)), 1'b0);
                else                        push_byte(random_letter(), 1'b0);
            end
            repeat ($urandom_range(0, 2)) push_byte(random_space(), 1'b0);
            push_byte(kvlt_tb_pkg::CHAR_EQ, 1'b0);
            // An empty value skips line ends too, so the value may start on
            // the next line.
            if ($urandom_range(99) < 5) push_byte(kvlt_tb_pkg::CHAR_LF, 1'b0);
            repeat ($urandom_range(0, 2)) push_byte(random_space(), 1'b0);
            runs = $urandom_range(0, 3);
            for (int r = 0; r <= runs; r++) begin
                if (r > 0) begin
                    if ($urandom_range(7) == 0)
                        n = $urandom_range(kvlt_pkg::SPACE_DEPTH - 1, kvlt_pkg::SPACE_DEPTH + 1);
                    else
                        n = $urandom_range(1, 3);
                    repeat (n) push_byte(random_space(), 1'b0);
                end
                repeat ($urandom_range(1, 5)) push_byte(random_solid(), 1'b0);
            end
            repeat ($urandom_range(0, 2)) push_byte(random_space(), 1'b0);
            roll = $urandom_range(99);
            if (roll < 45) begin
                push_byte(kvlt_tb_pkg::CHAR_LF, 1'b0);
            end
            else if (roll < 80) begin
                push_byte(kvlt_tb_pkg::CHAR_CR, 1'b0);
                push_byte(kvlt_tb_pkg::CHAR_LF, 1'b0);
            end
            else if (roll < 90) begin
                // CR not followed by LF is an error.
                push_byte(kvlt_tb_pkg::CHAR_CR, 1'b0);
                push_byte(random_solid(), 1'b0);
            end
        end
        if ($urandom_range(5) == 0) send_end();
    endtask

    initial
    begin
        token_board = new();
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        char_in    <= 8'h00;
        end_marker <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed text. A full line with leading whitespace, both letter
        // cases, whitespace before '=', a top byte in the value, a held
        // space and VT replayed ahead of the next byte, and CRLF.
        push_byte(kvlt_tb_pkg::CHAR_SP, 1'b0);
        push_byte(kvlt_tb_pkg::CHAR_TAB, 1'b0);
        send_text("Az =");
        push_byte(8'hFF, 1'b0);
        push_byte(kvlt_tb_pkg::CHAR_SP, 1'b0);
        push_byte(kvlt_tb_pkg::CHAR_VT, 1'b0);
        send_text("q");
        push_byte(kvlt_tb_pkg::CHAR_CR, 1'b0);
        push_byte(kvlt_tb_pkg::CHAR_LF, 1'b0);
        // Empty value closed by the end of text: pair end, then accept.
        send_text("a=");
        send_end();
        // A zero byte is a bad byte; the next byte is ignored and the end
        // of text reports the error.
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        send_end();
        // Empty text is accepted.
        send_end();
        // Text that stops inside a key is an error.
        send_text("k");
        send_end();
        // Missing final newline after a value is tolerated.
        send_text("v=w");
        send_end();
        wait_drained();

        // Random phases with different idle and stall rates. The first one
        // also runs the long receiver hold-off while bytes keep coming, and
        // every phase ends with the sender waiting for all results.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 73;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 73;
                end
                default:
                begin
                    send_idle_pct = 22;
                    stall_pct     = 22;
                end
            endcase
            bytes_sent = 0;
            if (ph == 0) hold_request <= 1'b1;
            while (bytes_sent < ITEMS_PER_PHASE) send_random_line();
            send_end();
            wait_drained();
        end

        // Anything the block still produces after this point has no
        // prediction and shows up as a mismatch.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (token_board.tokens_due.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     token_board.tokens_due.size());
        end
        if (token_board.mismatches == 0 && token_board.tokens_due.size() == 0) begin
            $display("status: pass");
        end
        else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== key_value_line_tokenizer_unit.f =====
rtl/kvlt_pkg.sv
rtl/kvlt_front.sv
rtl/kvlt_queue.sv
rtl/kvlt_back.sv
rtl/key_value_line_tokenizer_unit.sv
dv/kvlt_tb_pkg.sv
dv/tb_top.sv
